### hdl/upw_pkg.sv
// ----------------------------------------------------------------------------
// upw_pkg
// Shared types, codes and widths of the upwind advection grid step block.
// ----------------------------------------------------------------------------
package upw_pkg;

  localparam int FUNC_BITS  = 3;
  localparam int ROW_BITS   = 6;
  localparam int COL_BITS   = 6;
  localparam int VALUE_W    = 32;
  localparam int SIZE_BITS  = 7;
  localparam int CR_BITS    = 18;
  localparam int MAG_BITS   = 32;
  localparam int PROD_BITS  = 2 * MAG_BITS;
  localparam int ACC_BITS   = 54;
  localparam int RND_BITS   = 20;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = CR_BITS;

  localparam int UPW_MAX_ROWS   = 64;
  localparam int UPW_MAX_COLS   = 64;
  localparam int UPW_VALUE_BITS = 32;

  localparam logic [CR_BITS-1:0] COURANT_RST = CR_BITS'(65536);

  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_COLS = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COURANT   = 2'd2;

  localparam logic [FUNC_BITS-1:0] FUNC_WR_TEMP = 3'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_WR_U    = 3'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_WR_V    = 3'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_UPDATE  = 3'd3;
  localparam logic [FUNC_BITS-1:0] FUNC_SWAP    = 3'd4;

  typedef struct packed {
    logic [SIZE_BITS-1:0] rows;
    logic [SIZE_BITS-1:0] cols;
    logic [CR_BITS-1:0]   courant;
  } cfg_t;

  typedef struct packed {
    logic temp;
    logic u;
    logic v;
  } wr_en_t;

endpackage

### hdl/upw_in_if.sv
// ----------------------------------------------------------------------------
// upw_in_if
// Input channel: one command beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface upw_in_if import upw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_BITS-1:0] func;
  logic [ROW_BITS-1:0]  row;
  logic [COL_BITS-1:0]  col;
  logic [VALUE_W-1:0]   value;

  modport source (output valid, output func, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input func, input row, input col, input value,
                  output ready);
endinterface

### hdl/upw_out_if.sv
// ----------------------------------------------------------------------------
// upw_out_if
// Result channel: one result beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface upw_out_if import upw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] new_temperature;
  logic               saturated;
  logic               status;

  modport source (output valid, output new_temperature, output saturated,
                  output status, input ready);
  modport sink   (input valid, input new_temperature, input saturated,
                  input status, output ready);
endinterface

### hdl/upwind_advection_grid_step_top.sv
// ----------------------------------------------------------------------------
// upwind_advection_grid_step_top
// Writes and bank swaps go from accept straight to the done state.
// Cell update: centre read, then load and multiply states per interior face,
// then saturation; the shared multiplier runs three passes per face flux.
// One command at a time. Reset clears control state and loads the configuration defaults;
// the grid and velocity memories hold nothing valid until written.
// ----------------------------------------------------------------------------
module upwind_advection_grid_step_top import upw_pkg::*; #(
  parameter int MAX_ROWS   = UPW_MAX_ROWS,
  parameter int MAX_COLS   = UPW_MAX_COLS,
  parameter int VALUE_BITS = UPW_VALUE_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  upw_in_if.sink                   in_ch,
  upw_out_if.source                out_ch
);

  localparam int W  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
  localparam logic [AW-1:0] COL_STRIDE = AW'(MAX_COLS);
  localparam logic signed [ACC_BITS-1:0] HI_LIM = {{(ACC_BITS-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] LO_LIM = ~HI_LIM;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CTR  = 4'd1;
  localparam logic [3:0] S_CTRW = 4'd2;
  localparam logic [3:0] S_FACE = 4'd3;
  localparam logic [3:0] S_LOAD = 4'd4;
  localparam logic [3:0] S_MUL1 = 4'd5;
  localparam logic [3:0] S_MUL2 = 4'd6;
  localparam logic [3:0] S_MUL3 = 4'd7;
  localparam logic [3:0] S_SAT  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam logic [1:0] FACE_LEFT   = 2'd0;
  localparam logic [1:0] FACE_RIGHT  = 2'd1;
  localparam logic [1:0] FACE_BOTTOM = 2'd2;
  localparam logic [1:0] FACE_TOP    = 2'd3;

  cfg_t cfg;

  logic [3:0]                  state_r, state_nxt;
  logic                        bank_r, bank_nxt;
  logic [1:0]                  face_r, face_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ROW_BITS-1:0]         row_r, row_nxt;
  logic [COL_BITS-1:0]         col_r, col_nxt;
  logic [AW-1:0]               cell_r, cell_nxt;
  logic [W-1:0]                tc_r, tc_nxt;
  logic                        sub_r, sub_nxt;
  logic [MAG_BITS-1:0]         mhi_r, mhi_nxt;
  logic [RND_BITS-1:0]         rnd_r, rnd_nxt;
  logic signed [ACC_BITS-1:0]  acc_r, acc_nxt;
  logic [W-1:0]                res_temp_r, res_temp_nxt;
  logic                        res_sat_r, res_sat_nxt;
  logic                        res_stat_r, res_stat_nxt;
  logic [VALUE_W-1:0]          out_temp_r, out_temp_nxt;
  logic                        out_sat_r, out_sat_nxt;
  logic                        out_stat_r, out_stat_nxt;

  logic                        accept;
  logic [AW-1:0]               cell_in;
  logic                        row_ok, col_ok, u_ok, v_ok;
  logic                        face_has;
  logic [AW-1:0]               nb_addr, vel_addr;
  wr_en_t                      we;
  logic [AW:0]                 t_waddr, t_raddr;
  logic [W-1:0]                wdata;
  logic [W-1:0]                t_rdata, u_rdata, v_rdata, vel;
  logic                        take_center;
  logic [W-1:0]                t_sel;
  logic signed [MAG_BITS:0]    t_ext, v_ext, t_abs, v_abs;
  logic [MAG_BITS-1:0]         mul_a, mul_b;
  logic [PROD_BITS-1:0]        mul_p;
  logic [PROD_BITS-1:0]        rnd_sum;
  logic signed [ACC_BITS-1:0]  flux;

  upw_cfg #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  upw_store #(.ADDR_BITS(AW), .DATA_BITS(W)) u_store (
    .clk       (clk),
    .we        (we),
    .t_waddr   (t_waddr),
    .f_waddr   (cell_in),
    .wdata     (wdata),
    .t_raddr   (t_raddr),
    .f_raddr   (vel_addr),
    .t_rdata_r (t_rdata),
    .u_rdata_r (u_rdata),
    .v_rdata_r (v_rdata)
  );

  upw_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign in_ch.ready            = (state_r == S_IDLE);
  assign accept                 = in_ch.valid & in_ch.ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.new_temperature = out_temp_r;
  assign out_ch.saturated       = out_sat_r;
  assign out_ch.status          = out_stat_r;

  // command decode and range checks
  assign cell_in = AW'(AW'(in_ch.row) * COL_STRIDE + AW'(in_ch.col));
  assign row_ok  = {1'b0, in_ch.row} < cfg.rows;
  assign col_ok  = {1'b0, in_ch.col} < cfg.cols;
  assign u_ok    = row_ok & (({1'b0, in_ch.col} + 7'd1) < cfg.cols);
  assign v_ok    = col_ok & (({1'b0, in_ch.row} + 7'd1) < cfg.rows);

  // face geometry
  always_comb begin
    case (face_r)
      FACE_LEFT: begin
        face_has = (col_r != '0);
        nb_addr  = cell_r - AW'(1);
        vel_addr = cell_r - AW'(1);
      end
      FACE_RIGHT: begin
        face_has = ({1'b0, col_r} + 7'd1) < cfg.cols;
        nb_addr  = cell_r + AW'(1);
        vel_addr = cell_r;
      end
      FACE_BOTTOM: begin
        face_has = (row_r != '0);
        nb_addr  = cell_r - COL_STRIDE;
        vel_addr = cell_r - COL_STRIDE;
      end
      default: begin
        face_has = ({1'b0, row_r} + 7'd1) < cfg.rows;
        nb_addr  = cell_r + COL_STRIDE;
        vel_addr = cell_r;
      end
    endcase
  end

  assign t_raddr = (state_r == S_CTR) ? {bank_r, cell_r} : {bank_r, nb_addr};
  assign t_waddr = (state_r == S_SAT) ? {~bank_r, cell_r} : {bank_r, cell_in};

  // upwind operand and magnitudes
  assign vel         = face_r[1] ? v_rdata : u_rdata;
  assign take_center = face_r[0] ? (!vel[W-1] && (vel != '0)) : vel[W-1];
  assign t_sel       = take_center ? tc_r : t_rdata;
  assign t_ext       = (MAG_BITS+1)'(signed'(t_sel));
  assign v_ext       = (MAG_BITS+1)'(signed'(vel));
  assign t_abs       = t_sel[W-1] ? -t_ext : t_ext;
  assign v_abs       = vel[W-1] ? -v_ext : v_ext;

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_MUL1: begin
        mul_a = mul_p[MAG_BITS-1:0];
        mul_b = MAG_BITS'(cfg.courant);
      end
      S_MUL2: begin
        mul_a = mhi_r;
        mul_b = MAG_BITS'(cfg.courant);
      end
      default: begin
        mul_a = t_abs[MAG_BITS-1:0];
        mul_b = v_abs[MAG_BITS-1:0];
      end
    endcase
  end

  assign rnd_sum = mul_p + PROD_BITS'(64'h8000_0000);
  assign flux    = signed'({1'b0, mul_p[ACC_BITS-2:0]}) + signed'(ACC_BITS'(rnd_r));

  always_comb begin
    state_nxt     = state_r;
    bank_nxt      = bank_r;
    face_nxt      = face_r;
    out_valid_nxt = out_valid_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cell_nxt      = cell_r;
    tc_nxt        = tc_r;
    sub_nxt       = sub_r;
    mhi_nxt       = mhi_r;
    rnd_nxt       = rnd_r;
    acc_nxt       = acc_r;
    res_temp_nxt  = res_temp_r;
    res_sat_nxt   = res_sat_r;
    res_stat_nxt  = res_stat_r;
    out_temp_nxt  = out_temp_r;
    out_sat_nxt   = out_sat_r;
    out_stat_nxt  = out_stat_r;
    we            = '0;
    wdata         = in_ch.value[W-1:0];

    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          row_nxt      = in_ch.row;
          col_nxt      = in_ch.col;
          cell_nxt     = cell_in;
          res_temp_nxt = '0;
          res_sat_nxt  = 1'b0;
          res_stat_nxt = 1'b0;
          state_nxt    = S_DONE;
          case (in_ch.func)
            FUNC_WR_TEMP: begin
              we.temp      = row_ok & col_ok;
              res_stat_nxt = ~(row_ok & col_ok);
            end
            FUNC_WR_U: begin
              we.u         = u_ok;
              res_stat_nxt = ~u_ok;
            end
            FUNC_WR_V: begin
              we.v         = v_ok;
              res_stat_nxt = ~v_ok;
            end
            FUNC_UPDATE: begin
              if (row_ok && col_ok) begin
                state_nxt = S_CTR;
              end else begin
                res_stat_nxt = 1'b1;
              end
            end
            FUNC_SWAP: begin
              bank_nxt = ~bank_r;
            end
            default: begin
              res_stat_nxt = 1'b1;
            end
          endcase
        end
      end
      S_CTR: begin
        state_nxt = S_CTRW;
      end
      S_CTRW: begin
        tc_nxt    = t_rdata;
        acc_nxt   = ACC_BITS'(signed'(t_rdata));
        face_nxt  = FACE_LEFT;
        state_nxt = S_FACE;
      end
      S_FACE: begin
        if (face_has) begin
          state_nxt = S_LOAD;
        end else if (face_r == FACE_TOP) begin
          state_nxt = S_SAT;
        end else begin
          face_nxt = face_r + 2'd1;
        end
      end
      S_LOAD: begin
        // right and top faces subtract their flux
        sub_nxt   = t_sel[W-1] ^ vel[W-1] ^ face_r[0];
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        mhi_nxt   = mul_p[PROD_BITS-1:MAG_BITS];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        rnd_nxt   = rnd_sum[MAG_BITS+RND_BITS-1:MAG_BITS];
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        acc_nxt = sub_r ? (acc_r - flux) : (acc_r + flux);
        if (face_r == FACE_TOP) begin
          state_nxt = S_SAT;
        end else begin
          face_nxt  = face_r + 2'd1;
          state_nxt = S_FACE;
        end
      end
      S_SAT: begin
        if (acc_r > HI_LIM) begin
          wdata       = HI_LIM[W-1:0];
          res_sat_nxt = 1'b1;
        end else if (acc_r < LO_LIM) begin
          wdata       = LO_LIM[W-1:0];
          res_sat_nxt = 1'b1;
        end else begin
          wdata       = acc_r[W-1:0];
        end
        we.temp      = 1'b1;
        res_temp_nxt = wdata;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = VALUE_W'(signed'(res_temp_r));
          out_sat_nxt   = res_sat_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bank_r      <= 1'b0;
      face_r      <= FACE_LEFT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      face_r      <= face_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    cell_r     <= cell_nxt;
    tc_r       <= tc_nxt;
    sub_r      <= sub_nxt;
    mhi_r      <= mhi_nxt;
    rnd_r      <= rnd_nxt;
    acc_r      <= acc_nxt;
    res_temp_r <= res_temp_nxt;
    res_sat_r  <= res_sat_nxt;
    res_stat_r <= res_stat_nxt;
    out_temp_r <= out_temp_nxt;
    out_sat_r  <= out_sat_nxt;
    out_stat_r <= out_stat_nxt;
  end

endmodule

### hdl/upw_cfg.sv
// ----------------------------------------------------------------------------
// upw_cfg
// Configuration registers with grid size clamping on write.
// ----------------------------------------------------------------------------
module upw_cfg import upw_pkg::*; #(
  parameter int MAX_ROWS = UPW_MAX_ROWS,
  parameter int MAX_COLS = UPW_MAX_COLS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  localparam int ROWS_RST = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int COLS_RST = (MAX_COLS < 64) ? MAX_COLS : 64;

  logic [SIZE_BITS-1:0] rows_r, rows_nxt;
  logic [SIZE_BITS-1:0] cols_r, cols_nxt;
  logic [CR_BITS-1:0]   courant_r, courant_nxt;

  function automatic logic [SIZE_BITS-1:0] size_clamp(input logic [SIZE_BITS-1:0] v,
                                                      input logic [10:0] maxv);
    logic [SIZE_BITS-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_BITS'(1);
    end else if ({4'b0, v} > maxv) begin
      r = maxv[SIZE_BITS-1:0];
    end
    return r;
  endfunction

  always_comb begin
    rows_nxt    = rows_r;
    cols_nxt    = cols_r;
    courant_nxt = courant_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_ROWS: rows_nxt    = size_clamp(cfg_wdata[SIZE_BITS-1:0], 11'(MAX_ROWS));
        CFG_GRID_COLS: cols_nxt    = size_clamp(cfg_wdata[SIZE_BITS-1:0], 11'(MAX_COLS));
        CFG_COURANT:   courant_nxt = cfg_wdata[CR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= SIZE_BITS'(ROWS_RST);
      cols_r    <= SIZE_BITS'(COLS_RST);
      courant_r <= COURANT_RST;
    end else begin
      rows_r    <= rows_nxt;
      cols_r    <= cols_nxt;
      courant_r <= courant_nxt;
    end
  end

  assign cfg.rows    = rows_r;
  assign cfg.cols    = cols_r;
  assign cfg.courant = courant_r;

endmodule

### hdl/upw_mul.sv
// ----------------------------------------------------------------------------
// upw_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module upw_mul import upw_pkg::*; (
  input  logic                 clk,
  input  logic [MAG_BITS-1:0]  a,
  input  logic [MAG_BITS-1:0]  b,
  output logic [PROD_BITS-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= PROD_BITS'(a) * PROD_BITS'(b);
  end

endmodule

### hdl/upw_store.sv
// ----------------------------------------------------------------------------
// upw_store
// Temperature banks and face velocity memories with registered reads.
// ----------------------------------------------------------------------------
module upw_store import upw_pkg::*; #(
  parameter int ADDR_BITS = 12,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  wr_en_t               we,
  input  logic [ADDR_BITS:0]   t_waddr,
  input  logic [ADDR_BITS-1:0] f_waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS:0]   t_raddr,
  input  logic [ADDR_BITS-1:0] f_raddr,
  output logic [DATA_BITS-1:0] t_rdata_r,
  output logic [DATA_BITS-1:0] u_rdata_r,
  output logic [DATA_BITS-1:0] v_rdata_r
);

  localparam int DEPTH = 2 ** ADDR_BITS;

  logic [DATA_BITS-1:0] tmem [2*DEPTH];
  logic [DATA_BITS-1:0] umem [DEPTH];
  logic [DATA_BITS-1:0] vmem [DEPTH];

  always_ff @(posedge clk) begin
    if (we.temp) begin
      tmem[t_waddr] <= wdata;
    end
    t_rdata_r <= tmem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.u) begin
      umem[f_waddr] <= wdata;
    end
    u_rdata_r <= umem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.v) begin
      vmem[f_waddr] <= wdata;
    end
    v_rdata_r <= vmem[f_raddr];
  end

endmodule
